// ===== sv/m4mul_pkg.sv =====
// package for the fixed-point matrix multiplier
// shared types, command codes and default parameters; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package m4mul_pkg;

  // default sizes handed to the top level
  localparam int DIM_DEFAULT       = 4;
  localparam int FRAC_BITS_DEFAULT = 16;

  // field widths fixed by the interface
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 2;
  localparam int VALUE_W = 32;
  localparam int PROD_W  = 2 * VALUE_W;

  // input command codes
  localparam logic [CMD_W-1:0] CMD_LEFT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RIGHT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic wr_left;
    logic wr_right;
    logic issue;
    logic first_k;
    logic last_k;
    logic load_out;
    logic last_elem;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/matrix4_multiply_top.sv =====
// top level of the fixed-point matrix multiplier
// depends on m4mul_pkg, m4mul_ctrl, m4mul_dp (and m4mul_ram through it)
//
// usage
//   input channel (in_valid / in_stall): each transaction carries in_cmd,
//   in_row, in_col and in_value. load-left and load-right transactions
//   write one signed q16.16 element each; a write with
//   row or column beyond the matrix size, or an unused command, is dropped.
//   a compute transaction emits the DIM*DIM product elements on the result
//   channel (out_valid / out_stall) in row-major order, out_last marking
//   the final one and out_saturated marking clipped elements.
//   sequencing: a single multiply-accumulate unit, fed by one read port
//   per operand store, steps through the DIM inner-product terms of each
//   element in a read, multiply and accumulate pipeline; the next element
//   is not started until the previous one has been accumulated.
//   the input is stalled for the whole of a compute.
//   receiver stall: the finished element waits in the output register; the
//   next element is still accumulated and then waits in the accumulator
//   until that slot frees, after which sequencing resumes.
//   reset: synchronous, active low; both stores read as zero after reset
//   through per-entry written flags, and no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module matrix4_multiply_top #(
  parameter int DIM       = m4mul_pkg::DIM_DEFAULT,
  parameter int FRAC_BITS = m4mul_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [m4mul_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic [m4mul_pkg::IDX_W-1:0]          in_row,
  input  wire logic [m4mul_pkg::IDX_W-1:0]          in_col,
  input  wire logic signed [m4mul_pkg::VALUE_W-1:0] in_value,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [m4mul_pkg::IDX_W-1:0]               out_row,
  output logic [m4mul_pkg::IDX_W-1:0]               out_col,
  output logic signed [m4mul_pkg::VALUE_W-1:0]      out_product,
  output logic                                      out_saturated,
  output logic                                      out_last
);

  // command and status between controller and datapath
  m4mul_pkg::ctrl_cmd_t    cmd;
  m4mul_pkg::dp_stat_t     stat;
  // current element (i, j) and inner-product step k
  logic [$clog2(DIM)-1:0]  i_idx, j_idx, k_idx;

  // sequencer: decodes transactions and walks i, j, k
  m4mul_ctrl #(.DIM(DIM)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_row   (in_row),
    .in_col   (in_col),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd),
    .i_idx    (i_idx),
    .j_idx    (j_idx),
    .k_idx    (k_idx)
  );

  // stores, mac pipeline, scaling, saturation and output register
  m4mul_dp #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .i_idx         (i_idx),
    .j_idx         (j_idx),
    .k_idx         (k_idx),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_value      (in_value),
    .out_stall     (out_stall),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_product   (out_product),
    .out_saturated (out_saturated),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// ===== sv/m4mul_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module m4mul_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/m4mul_dp.sv =====
// datapath: operand stores, multiply-accumulate pipeline, scaling,
// saturation and output register; uses m4mul_pkg and m4mul_ram
`timescale 1ns / 1ps
`default_nettype none

module m4mul_dp #(
  parameter int DIM       = m4mul_pkg::DIM_DEFAULT,
  parameter int FRAC_BITS = m4mul_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire m4mul_pkg::ctrl_cmd_t               cmd,
  input  wire logic [$clog2(DIM)-1:0]             i_idx,
  input  wire logic [$clog2(DIM)-1:0]             j_idx,
  input  wire logic [$clog2(DIM)-1:0]             k_idx,
  input  wire logic [m4mul_pkg::IDX_W-1:0]        in_row,
  input  wire logic [m4mul_pkg::IDX_W-1:0]        in_col,
  input  wire logic signed [m4mul_pkg::VALUE_W-1:0] in_value,
  input  wire logic                               out_stall,
  output m4mul_pkg::dp_stat_t                     stat,
  output logic                                    out_valid,
  output logic [m4mul_pkg::IDX_W-1:0]             out_row,
  output logic [m4mul_pkg::IDX_W-1:0]             out_col,
  output logic signed [m4mul_pkg::VALUE_W-1:0]    out_product,
  output logic                                    out_saturated,
  output logic                                    out_last
);

  localparam int DEPTH  = DIM * DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int VW     = m4mul_pkg::VALUE_W;
  localparam int PW     = m4mul_pkg::PROD_W;
  localparam int ACC_W  = PW + $clog2(DIM);

  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] l_raddr;
  logic [ADDR_W-1:0] r_raddr;
  logic [VW-1:0]     l_rdata;
  logic [VW-1:0]     r_rdata;

  assign waddr   = ADDR_W'(32'(in_row) * DIM + 32'(in_col));
  assign l_raddr = ADDR_W'(32'(i_idx) * DIM + 32'(k_idx));
  assign r_raddr = ADDR_W'(32'(k_idx) * DIM + 32'(j_idx));

  m4mul_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (cmd.wr_left),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  m4mul_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (cmd.wr_right),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // written flags, an entry never written reads as zero
  logic [DEPTH-1:0] lv_r, lv_nxt;
  logic [DEPTH-1:0] rv_r, rv_nxt;
  logic             lrv_r, rrv_r;

  always_comb begin
    lv_nxt = lv_r;
    rv_nxt = rv_r;
    if (cmd.wr_left) begin
      lv_nxt[waddr] = 1'b1;
    end
    if (cmd.wr_right) begin
      rv_nxt[waddr] = 1'b1;
    end
  end

  // pipeline: read, multiply, accumulate
  logic                 rd_vld_r, rd_first_r, rd_last_r;
  logic                 mul_vld_r, mul_first_r, mul_last_r;
  logic signed [VW-1:0] op_l, op_r;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] prod_r;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                 acc_done_r, acc_done_nxt;

  assign op_l     = lrv_r ? $signed(l_rdata) : '0;
  assign op_r     = rrv_r ? $signed(r_rdata) : '0;
  assign prod_nxt = op_l * op_r;
  assign prod_ext = {{(ACC_W - PW){prod_r[PW-1]}}, prod_r};

  always_comb begin
    acc_nxt = acc_r;
    if (mul_vld_r) begin
      acc_nxt = mul_first_r ? prod_ext : acc_r + prod_ext;
    end
    acc_done_nxt = acc_done_r;
    if (cmd.load_out || (cmd.issue && cmd.first_k)) begin
      acc_done_nxt = 1'b0;
    end else if (mul_vld_r && mul_last_r) begin
      acc_done_nxt = 1'b1;
    end
  end

  // scaling and saturation
  logic signed [ACC_W-1:0] shifted;
  logic [ACC_W-VW:0]       upper;
  logic                    fits;
  logic [VW-1:0]           res_val;

  assign shifted = acc_r >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:VW-1];
  assign fits    = (&upper) || !(|upper);

  always_comb begin
    if (fits) begin
      res_val = shifted[VW-1:0];
    end else if (shifted[ACC_W-1]) begin
      res_val = {1'b1, {(VW-1){1'b0}}};
    end else begin
      res_val = {1'b0, {(VW-1){1'b1}}};
    end
  end

  // output register
  logic                           out_valid_r, out_valid_nxt;
  logic [m4mul_pkg::IDX_W-1:0]    out_row_r, out_col_r;
  logic [VW-1:0]                  out_product_r;
  logic                           out_sat_r, out_last_r;

  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.acc_done = acc_done_r;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r        <= '0;
      rv_r        <= '0;
      rd_vld_r    <= 1'b0;
      mul_vld_r   <= 1'b0;
      acc_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lv_r        <= lv_nxt;
      rv_r        <= rv_nxt;
      rd_vld_r    <= cmd.issue;
      mul_vld_r   <= rd_vld_r;
      acc_done_r  <= acc_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lrv_r       <= lv_r[l_raddr];
    rrv_r       <= rv_r[r_raddr];
    rd_first_r  <= cmd.first_k;
    rd_last_r   <= cmd.last_k;
    mul_first_r <= rd_first_r;
    mul_last_r  <= rd_last_r;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    if (cmd.load_out) begin
      out_row_r     <= 2'(i_idx);
      out_col_r     <= 2'(j_idx);
      out_product_r <= res_val;
      out_sat_r     <= !fits;
      out_last_r    <= cmd.last_elem;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_product   = $signed(out_product_r);
  assign out_saturated = out_sat_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// ===== sv/m4mul_ctrl.sv =====
// controller: command decode and element / inner-product sequencing
// uses m4mul_pkg
`timescale 1ns / 1ps
`default_nettype none

module m4mul_ctrl #(
  parameter int DIM = m4mul_pkg::DIM_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [m4mul_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [m4mul_pkg::IDX_W-1:0]   in_row,
  input  wire logic [m4mul_pkg::IDX_W-1:0]   in_col,
  output logic                               in_stall,
  input  wire m4mul_pkg::dp_stat_t           stat,
  output m4mul_pkg::ctrl_cmd_t               cmd,
  output logic [$clog2(DIM)-1:0]             i_idx,
  output logic [$clog2(DIM)-1:0]             j_idx,
  output logic [$clog2(DIM)-1:0]             k_idx
);

  localparam int IW = $clog2(DIM);
  localparam logic [IW-1:0] TOP = IW'(DIM - 1);

  m4mul_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]     i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic              in_range;

  assign in_range = (32'(in_row) < DIM) && (32'(in_col) < DIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= m4mul_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      m4mul_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (in_cmd)
            m4mul_pkg::CMD_LEFT:    cmd.wr_left  = in_range;
            m4mul_pkg::CMD_RIGHT:   cmd.wr_right = in_range;
            m4mul_pkg::CMD_COMPUTE: begin
              state_nxt = m4mul_pkg::ST_RUN;
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
            end
            default: ;
          endcase
        end
      end
      m4mul_pkg::ST_RUN: begin
        cmd.issue   = 1'b1;
        cmd.first_k = (k_r == '0);
        cmd.last_k  = (k_r == TOP);
        if (k_r == TOP) begin
          k_nxt     = '0;
          state_nxt = m4mul_pkg::ST_FINISH;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      m4mul_pkg::ST_FINISH: begin
        if (stat.acc_done && stat.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.last_elem = (i_r == TOP) && (j_r == TOP);
          if (j_r == TOP) begin
            j_nxt = '0;
            if (i_r == TOP) begin
              i_nxt     = '0;
              state_nxt = m4mul_pkg::ST_IDLE;
            end else begin
              i_nxt     = i_r + IW'(1);
              state_nxt = m4mul_pkg::ST_RUN;
            end
          end else begin
            j_nxt     = j_r + IW'(1);
            state_nxt = m4mul_pkg::ST_RUN;
          end
        end
      end
      default: state_nxt = m4mul_pkg::ST_IDLE;
    endcase
  end

  assign i_idx = i_r;
  assign j_idx = j_r;
  assign k_idx = k_r;

  a_load_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (stat.acc_done && stat.out_free))
    else $error("result loaded before accumulation finished or slot free");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cmd.last_elem) |=> (state_r == m4mul_pkg::ST_IDLE))
    else $error("controller did not return to idle after final element");

  a_issue_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue || cmd.load_out) |-> in_stall)
    else $error("input accepted while a product is in progress");

  a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == m4mul_pkg::ST_IDLE && in_valid && in_cmd == m4mul_pkg::CMD_COMPUTE)
    |=> (state_r == m4mul_pkg::ST_RUN && i_r == '0 && j_r == '0 && k_r == '0))
    else $error("compute did not start at element zero");

endmodule

`default_nettype wire
